// ===== src/ppt_pkg.sv =====
package ppt_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 16;
  localparam int MIN_VALID    = 3;

  localparam int IDX_W    = $clog2(MAX_VERTICES);
  localparam int CNT_W    = $clog2(MAX_VERTICES + 1);
  localparam int RD_W     = $clog2(MAX_VERTICES + 2);
  localparam int AREA_W   = 38;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;

  // operand, product, edge term and accumulator widths
  localparam int OP_W   = COORD_BITS + 1;
  localparam int PROD_W = 2 * OP_W;
  localparam int DIFF_W = PROD_W + 1;
  localparam int ACC_W  = 2 * COORD_BITS + IDX_W + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [OP_W-1:0]       op_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD    = 2'd0,
    ACT_TEST    = 2'd1,
    ACT_MEASURE = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_TOO_FEW = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

  // sign-extend a coordinate by one bit
  function automatic op_t sx1(input coord_t v);
    sx1 = $signed({v[COORD_BITS-1], v});
  endfunction

endpackage

// ===== src/ppt_if.sv =====
interface ppt_in_if;
  import ppt_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic                       start_new;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;

  modport source (output valid, action, start_new, coord_x, coord_y, input ready);
  modport sink   (input valid, action, start_new, coord_x, coord_y, output ready);
endinterface

interface ppt_out_if;
  import ppt_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         inside_res;
  logic [AREA_W-1:0]            doubled_area;
  logic signed [COORD_BITS-1:0] box_min_x;
  logic signed [COORD_BITS-1:0] box_max_x;
  logic signed [COORD_BITS-1:0] box_min_y;
  logic signed [COORD_BITS-1:0] box_max_y;
  logic [CNT_W-1:0]             vertex_total;
  logic [STATUS_W-1:0]          status;

  modport source (output valid, inside_res, doubled_area, box_min_x, box_max_x,
                  box_min_y, box_max_y, vertex_total, status, input ready);
  modport sink   (input valid, inside_res, doubled_area, box_min_x, box_max_x,
                  box_min_y, box_max_y, vertex_total, status, output ready);
endinterface

// ===== src/polygon_point_test_area.sv =====
// Polygon point test and area block.
// in_ch carries one item per valid/ready handshake: a load appends a vertex
// (start_new empties the polygon first), a test asks for the even-odd
// crossing parity of a point, a measure asks for twice the shoelace area
// and the bounding box. Every item gives exactly one item on out_ch.
// The block takes one item at a time. Loads, unused codes and queries on
// fewer than three vertices skip the walk and go to the finish state. Test
// and measure walk the vertex memory one entry per cycle, then one closing
// edge, through a four-stage read / edge / multiply / difference pipeline
// into the accumulator. The vertex memory has a single read port.
// The output register holds a finished item while out_ch.ready is low; one
// further item is accepted and worked on meanwhile, then waits until the
// register frees. Reset empties the polygon and the output register; the
// vertex memory itself is not cleared, only entries below the count are read.
module polygon_point_test_area (
  input  logic         clk,
  input  logic         rst,
  ppt_in_if.sink       in_ch,
  ppt_out_if.source    out_ch
);
  import ppt_pkg::*;

  state_t state, state_next;

  // vertex memory, {y, x} per entry
  logic [2*COORD_BITS-1:0] vmem [MAX_VERTICES];
  logic [2*COORD_BITS-1:0] mem_q;
  logic                    mem_we, mem_re;
  logic [IDX_W-1:0]        mem_wa;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  cnt_eff;
  logic              in_acc;
  logic              rd_en;
  logic              out_load;

  // held item
  action_t           act;
  logic [STATUS_W-1:0] stat;
  coord_t            px, py;
  logic [RD_W-1:0]   rd_idx;

  // pipeline
  logic              s1_vld, s1_first, s1_wrap;
  coord_t            first_x, first_y, prev_x, prev_y;
  coord_t            cur_x, cur_y;
  logic              e_vld, e_last, e_cond, e_dpos;
  op_t               m1l, m1r, m2l, m2r;
  logic              p_vld, p_last, p_cond, p_dpos;
  logic signed [PROD_W-1:0] p1, p2;
  logic              q_vld, q_last, q_cross;
  logic signed [DIFF_W-1:0] q_diff;

  // results being gathered
  logic              parity;
  logic signed [ACC_W-1:0] acc;
  coord_t            bmin_x, bmax_x, bmin_y, bmax_y;

  // output register
  logic              out_valid;
  logic              o_inside;
  logic [AREA_W-1:0] o_area;
  coord_t            o_min_x, o_max_x, o_min_y, o_max_y;
  logic [CNT_W-1:0]  o_total;
  logic [STATUS_W-1:0] o_status;

  // finished fields
  logic              good, is_test, is_meas;
  logic [ACC_W-1:0]  mag;
  logic [AREA_W-1:0] area_sat;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cnt_eff = in_ch.start_new ? '0 : count;
  assign mem_we  = in_acc && (in_ch.action == ACT_LOAD) &&
                   (cnt_eff < CNT_W'(MAX_VERTICES));
  assign mem_wa  = cnt_eff[IDX_W-1:0];
  assign mem_re  = rd_en && (rd_idx != RD_W'(count));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (((in_ch.action == ACT_TEST) || (in_ch.action == ACT_MEASURE)) &&
              (count >= CNT_W'(MIN_VALID))) begin
            state_next = ST_WALK;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_WALK: begin
        if (q_vld && q_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready = 1'b0;
    rd_en       = 1'b0;
    out_load    = 1'b0;
    case (state)
      ST_IDLE:   in_ch.ready = 1'b1;
      ST_WALK:   rd_en = (rd_idx <= RD_W'(count));
      ST_FINISH: out_load = !out_valid || out_ch.ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // vertex memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      vmem[mem_wa] <= {in_ch.coord_y, in_ch.coord_x};
    end
    if (mem_re) begin
      mem_q <= vmem[rd_idx[IDX_W-1:0]];
    end
  end

  // vertex count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_acc && (in_ch.action == ACT_LOAD)) begin
      if (mem_we) begin
        count <= cnt_eff + 1'b1;
      end else begin
        count <= cnt_eff;
      end
    end
  end

  // item capture and read address walk
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act    <= action_t'(in_ch.action);
      px     <= in_ch.coord_x;
      py     <= in_ch.coord_y;
      rd_idx <= '0;
      case (in_ch.action)
        ACT_LOAD:    stat <= mem_we ? STAT_OK : STAT_FULL;
        ACT_TEST,
        ACT_MEASURE: stat <= (count < CNT_W'(MIN_VALID)) ? STAT_TOO_FEW : STAT_OK;
        default:     stat <= STAT_OK;
      endcase
    end else if (rd_en) begin
      rd_idx <= rd_idx + 1'b1;
    end
  end

  // read stage flags; the extra slot after the last read is the closing edge
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= rd_en;
    end
    s1_first <= (rd_idx == '0);
    s1_wrap  <= !mem_re;
  end

  assign cur_x = s1_wrap ? first_x : coord_t'(mem_q[COORD_BITS-1:0]);
  assign cur_y = s1_wrap ? first_y : coord_t'(mem_q[2*COORD_BITS-1:COORD_BITS]);

  // edge stage: edge runs from prev (j) to cur (i)
  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= s1_vld && !s1_first;
    end
    if (s1_vld) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
      if (s1_first) begin
        first_x <= cur_x;
        first_y <= cur_y;
      end
    end
    e_last <= s1_wrap;
    e_cond <= (cur_y > py) != (prev_y > py);
    e_dpos <= prev_y > cur_y;
    if (act == ACT_TEST) begin
      m1l <= sx1(px) - sx1(cur_x);
      m1r <= sx1(prev_y) - sx1(cur_y);
      m2l <= sx1(prev_x) - sx1(cur_x);
      m2r <= sx1(py) - sx1(cur_y);
    end else begin
      m1l <= sx1(prev_x);
      m1r <= sx1(cur_y);
      m2l <= sx1(cur_x);
      m2r <= sx1(prev_y);
    end
  end

  // bounding box over real vertices only
  always_ff @(posedge clk) begin
    if (s1_vld && !s1_wrap) begin
      if (s1_first) begin
        bmin_x <= cur_x;
        bmax_x <= cur_x;
        bmin_y <= cur_y;
        bmax_y <= cur_y;
      end else begin
        if (cur_x < bmin_x) bmin_x <= cur_x;
        if (cur_x > bmax_x) bmax_x <= cur_x;
        if (cur_y < bmin_y) bmin_y <= cur_y;
        if (cur_y > bmax_y) bmax_y <= cur_y;
      end
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= e_vld;
    end
    p_last <= e_last;
    p_cond <= e_cond;
    p_dpos <= e_dpos;
    p1     <= m1l * m1r;
    p2     <= m2l * m2r;
  end

  // difference / crossing stage
  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld <= 1'b0;
    end else begin
      q_vld <= p_vld;
    end
    q_last  <= p_last;
    q_diff  <= $signed({p1[PROD_W-1], p1}) - $signed({p2[PROD_W-1], p2});
    q_cross <= p_cond && (p_dpos ? (p1 < p2) : (p1 > p2));
  end

  // accumulate
  always_ff @(posedge clk) begin
    if (in_acc) begin
      acc    <= '0;
      parity <= 1'b0;
    end else if (q_vld) begin
      acc    <= acc + $signed({{(ACC_W-DIFF_W){q_diff[DIFF_W-1]}}, q_diff});
      parity <= parity ^ q_cross;
    end
  end

  // finished fields
  assign good     = (stat == STAT_OK);
  assign is_test  = good && (act == ACT_TEST);
  assign is_meas  = good && (act == ACT_MEASURE);
  assign mag      = acc[ACC_W-1] ? (~acc + 1'b1) : acc;
  assign area_sat = (|mag[ACC_W-1:AREA_W]) ? '1 : mag[AREA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      o_inside <= is_test && parity;
      o_area   <= is_meas ? area_sat : '0;
      o_min_x  <= is_meas ? bmin_x : '0;
      o_max_x  <= is_meas ? bmax_x : '0;
      o_min_y  <= is_meas ? bmin_y : '0;
      o_max_y  <= is_meas ? bmax_y : '0;
      o_total  <= count;
      o_status <= stat;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.inside_res   = o_inside;
  assign out_ch.doubled_area = o_area;
  assign out_ch.box_min_x    = o_min_x;
  assign out_ch.box_max_x    = o_max_x;
  assign out_ch.box_min_y    = o_min_y;
  assign out_ch.box_max_y    = o_max_y;
  assign out_ch.vertex_total = o_total;
  assign out_ch.status       = o_status;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import ppt_pkg::*;

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------
  localparam int CLK_HALF     = 6;           // 12 ns period
  localparam int RESET_CYCLES = 7;
  localparam int TARGET_ITEMS = 1100;        // random part stops past this
  localparam int IDLE_PCT     = 12;          // idle cycles per hundred, each side
  localparam int QUIET_FIRST  = 500;         // items in [QUIET_FIRST, QUIET_LAST)
  localparam int QUIET_LAST   = 700;         // run with no idling on either side
  localparam int DRAIN_CYCLES = 80;          // longer than a walk of 64 vertices
  localparam int TIMEOUT_NS   = 12_000_000;  // in ns
  localparam int REPORT_MAX   = 10;

  // action code 3 has no member in the package enum
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic [AREA_W-1:0] AREA_SAT = {AREA_W{1'b1}};

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic                start_new;
    coord_t              x;
    coord_t              y;
  } poly_item_t;

  typedef struct {
    logic              in_poly;
    logic [AREA_W-1:0] area;
    coord_t            min_x;
    coord_t            max_x;
    coord_t            min_y;
    coord_t            max_y;
    logic [CNT_W-1:0]  total;
    status_t           status;
  } poly_result_t;

  // ---------------------------------------------------------------------------
  // Polygon tracker: own copy of the vertex store, predicts one result per
  // accepted item and checks the block's results against them in order.
  // ---------------------------------------------------------------------------
  class polygon_tracker;
    coord_t       vert_x[MAX_VERTICES];
    coord_t       vert_y[MAX_VERTICES];
    int           count;
    poly_result_t expected_q[$];
    int           fails;

    function new();
      count = 0;
      fails = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_item(poly_item_t it);
      poly_result_t r;
      longint       xi, yi, xj, yj, px, py, d, lhs, rhs, sum, mag;
      bit           odd, crossed;
      int           j, nx;

      r.in_poly = 1'b0;
      r.area    = '0;
      r.min_x   = '0;
      r.max_x   = '0;
      r.min_y   = '0;
      r.max_y   = '0;
      r.status  = STAT_OK;
      px = longint'(it.x);
      py = longint'(it.y);

      case (it.action)
        ACT_LOAD: begin
          // clear comes first, so a restart on a full store still lands
          if (it.start_new) count = 0;
          if (count < MAX_VERTICES) begin
            vert_x[count] = it.x;
            vert_y[count] = it.y;
            count++;
          end else begin
            r.status = STAT_FULL;
          end
        end
        ACT_TEST: begin
          if (count < MIN_VALID) begin
            r.status = STAT_TOO_FEW;
          end else begin
            // even-odd crossing, division replaced by cross-multiplication
            odd = 1'b0;
            j   = count - 1;
            for (int i = 0; i < count; i++) begin
              xi = longint'(vert_x[i]);
              yi = longint'(vert_y[i]);
              xj = longint'(vert_x[j]);
              yj = longint'(vert_y[j]);
              if ((yi > py) != (yj > py)) begin
                d   = yj - yi;
                lhs = (px - xi) * d;
                rhs = (xj - xi) * (py - yi);
                crossed = (d > 0) ? (lhs < rhs) : (lhs > rhs);
                if (crossed) odd = !odd;
              end
              j = i;
            end
            r.in_poly = odd;
          end
        end
        ACT_MEASURE: begin
          if (count < MIN_VALID) begin
            r.status = STAT_TOO_FEW;
          end else begin
            sum     = 0;
            r.min_x = vert_x[0];
            r.max_x = vert_x[0];
            r.min_y = vert_y[0];
            r.max_y = vert_y[0];
            for (int i = 0; i < count; i++) begin
              nx = (i + 1 == count) ? 0 : i + 1;
              xi = longint'(vert_x[i]);
              yi = longint'(vert_y[i]);
              xj = longint'(vert_x[nx]);
              yj = longint'(vert_y[nx]);
              sum += xi * yj - xj * yi;
              if (vert_x[i] < r.min_x) r.min_x = vert_x[i];
              if (vert_x[i] > r.max_x) r.max_x = vert_x[i];
              if (vert_y[i] < r.min_y) r.min_y = vert_y[i];
              if (vert_y[i] > r.max_y) r.max_y = vert_y[i];
            end
            mag = (sum < 0) ? -sum : sum;
            r.area = (mag > longint'(AREA_SAT)) ? AREA_SAT : mag[AREA_W-1:0];
          end
        end
        default: ;  // unused code leaves the polygon alone
      endcase

      r.total = CNT_W'(count);
      expected_q.push_back(r);
    endfunction

    function void check_result(poly_result_t got);
      poly_result_t want;

      if (expected_q.size() == 0) begin
        fails++;
        if (fails <= REPORT_MAX)
          $display("%0t: result item with none pending: n=%0d st=%0d",
                   $realtime, got.total, got.status);
        return;
      end
      want = expected_q.pop_front();
      if (got.in_poly !== want.in_poly || got.area !== want.area ||
          got.min_x !== want.min_x || got.max_x !== want.max_x ||
          got.min_y !== want.min_y || got.max_y !== want.max_y ||
          got.total !== want.total || got.status !== want.status) begin
        fails++;
        if (fails <= REPORT_MAX) begin
          $display("%0t: mismatch exp in=%0d area=%0d box=%0d..%0d,%0d..%0d n=%0d st=%0d",
                   $realtime, want.in_poly, want.area, want.min_x, want.max_x,
                   want.min_y, want.max_y, want.total, want.status);
          $display("%0t:          got in=%0d area=%0d box=%0d..%0d,%0d..%0d n=%0d st=%0d",
                   $realtime, got.in_poly, got.area, got.min_x, got.max_x,
                   got.min_y, got.max_y, got.total, got.status);
        end
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst;

  ppt_in_if  in_ch();
  ppt_out_if out_ch();

  polygon_point_test_area DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  polygon_tracker tracker = new();

  int items_sent = 0;
  bit no_idle    = 1'b0;   // set across the quiet window, read by both sides

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, check on every handshake.
  // Values are read right after the edge, before any NBA of that edge lands.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_side
    poly_result_t got;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.in_poly = out_ch.inside_res;
        got.area    = out_ch.doubled_area;
        got.min_x   = out_ch.box_min_x;
        got.max_x   = out_ch.box_max_x;
        got.min_y   = out_ch.box_min_y;
        got.max_y   = out_ch.box_max_y;
        got.total   = out_ch.vertex_total;
        got.status  = status_t'(out_ch.status);
        tracker.check_result(got);
      end
      out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Item side
  // ---------------------------------------------------------------------------

  // One item: random idle cycles first (valid low), then hold valid until
  // the block takes it. valid gets one NBA per time step.
  task automatic send_item(input logic [ACTION_W-1:0] action, input logic start_new,
                           input coord_t x, input coord_t y);
    poly_item_t it;
    it.action    = action;
    it.start_new = start_new;
    it.x         = x;
    it.y         = y;
    no_idle = (items_sent >= QUIET_FIRST) && (items_sent < QUIET_LAST);
    while (!no_idle && ($urandom_range(99) < IDLE_PCT)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= action;
    in_ch.start_new <= start_new;
    in_ch.coord_x   <= x;
    in_ch.coord_y   <= y;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_item(it);
    items_sent++;
  endtask

  // Coordinate styles: 0 anywhere, 1 cluster around a center (dense, lots of
  // shared y values), 2 coarse grid (horizontal and collinear edges),
  // 3 extremes of the 16-bit range.
  function automatic coord_t pick_coord(int style, int center, int spread);
    int off;
    case (style)
      0: return coord_t'($urandom);
      1: begin
        off = int'($urandom_range(2 * spread)) - spread;
        return coord_t'(center + off);
      end
      2: begin
        off = int'($urandom_range(4)) - 2;
        return coord_t'(center + off * spread);
      end
      default: begin
        case ($urandom_range(3))
          0: return coord_t'(16'sh8000);
          1: return coord_t'(16'sh7fff);
          2: return coord_t'(16'sh0000);
          default: return coord_t'(16'shffff);
        endcase
      end
    endcase
  endfunction

  // Well-formed polygon: restart, n vertices, a few tests, some measures.
  // Most are small; a few fill the store and some push past it.
  task automatic run_polygon();
    int     n, style, center, spread, tests, pick, idx;
    coord_t vx[$];
    coord_t vy[$];
    coord_t px, py;

    pick = $urandom_range(99);
    if (pick < 80)      n = $urandom_range(10, MIN_VALID);
    else if (pick < 92) n = $urandom_range(40, 11);
    else if (pick < 97) n = $urandom_range(MAX_VERTICES, MAX_VERTICES - 4);
    else                n = $urandom_range(MAX_VERTICES + 6, MAX_VERTICES + 1);
    style  = $urandom_range(3);
    center = int'($urandom_range(65535)) - 32768;
    case ($urandom_range(2))
      0:       spread = 15;
      1:       spread = 255;
      default: spread = 4095;
    endcase

    for (int i = 0; i < n; i++) begin
      px = pick_coord(style, center, spread);
      py = pick_coord(style, center, spread);
      vx.push_back(px);
      vy.push_back(py);
      // rare restart mid-way breaks the sequence
      send_item(ACT_LOAD, (i == 0) || ($urandom_range(99) < 2), px, py);
    end

    tests = $urandom_range(6, 1);
    for (int t = 0; t < tests; t++) begin
      pick = $urandom_range(99);
      idx  = $urandom_range(vx.size() - 1);
      if (pick < 50) begin
        px = pick_coord(style, center, spread);
        py = pick_coord(style, center, spread);
      end else if (pick < 75) begin
        // query on a vertex's scan line
        px = pick_coord(style, center, spread);
        py = vy[idx];
      end else if (pick < 85) begin
        px = vx[idx];
        py = vy[idx];
      end else begin
        px = coord_t'($urandom);
        py = coord_t'($urandom);
      end
      send_item(ACT_TEST, 1'($urandom_range(1)), px, py);
      if ($urandom_range(99) < 30)
        send_item(ACT_MEASURE, 1'($urandom_range(1)), coord_t'($urandom),
                  coord_t'($urandom));
    end
    send_item(ACT_MEASURE, 1'($urandom_range(1)), coord_t'($urandom), coord_t'($urandom));
  endtask

  // Noise: any action incl. the unused code, start_new and coords at random.
  // Loads here append to whatever is stored, so a full store gets refusals.
  task automatic run_noise();
    int cnt;
    cnt = $urandom_range(10, 4);
    for (int i = 0; i < cnt; i++)
      send_item(ACTION_W'($urandom_range(3)), ($urandom_range(99) < 15),
                coord_t'($urandom), coord_t'($urandom));
  endtask

  // Broken polygon: one or two vertices, then queries that must say too few.
  task automatic run_short_polygon();
    int cnt;
    cnt = $urandom_range(MIN_VALID - 1, 1);
    for (int i = 0; i < cnt; i++)
      send_item(ACT_LOAD, (i == 0), coord_t'($urandom), coord_t'($urandom));
    send_item(ACT_TEST, 1'($urandom_range(1)), coord_t'($urandom), coord_t'($urandom));
    if ($urandom_range(1))
      send_item(ACT_UNUSED, 1'($urandom_range(1)), coord_t'($urandom),
                coord_t'($urandom));
    send_item(ACT_MEASURE, 1'($urandom_range(1)), coord_t'($urandom), coord_t'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int pick;

    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ACT_LOAD;
    in_ch.start_new <= 1'b0;
    in_ch.coord_x   <= '0;
    in_ch.coord_y   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // empty polygon: queries answer too few
    send_item(ACT_TEST,    1'b0, 16'sd0, 16'sd0);
    send_item(ACT_MEASURE, 1'b0, 16'sd0, 16'sd0);
    // unused code with start_new set must not clear anything
    send_item(ACT_UNUSED,  1'b1, -16'sd1, -16'sd1);
    // full-range square, with a too-few measure after two vertices
    send_item(ACT_LOAD,    1'b1, coord_t'(16'sh8000), coord_t'(16'sh8000));
    send_item(ACT_LOAD,    1'b0, coord_t'(16'sh7fff), coord_t'(16'sh8000));
    send_item(ACT_MEASURE, 1'b0, 16'sd0, 16'sd0);
    send_item(ACT_LOAD,    1'b0, coord_t'(16'sh7fff), coord_t'(16'sh7fff));
    send_item(ACT_LOAD,    1'b0, coord_t'(16'sh8000), coord_t'(16'sh7fff));
    send_item(ACT_MEASURE, 1'b0, 16'sd0, 16'sd0);            // largest area
    send_item(ACT_TEST,    1'b0, 16'sd0, 16'sd0);
    send_item(ACT_TEST,    1'b0, coord_t'(16'sh8000), coord_t'(16'sh8000));
    send_item(ACT_TEST,    1'b0, coord_t'(16'sh7fff), 16'sd0);
    send_item(ACT_TEST,    1'b0, coord_t'(16'sh8000), 16'sd0);
    send_item(ACT_TEST,    1'b1, 16'sd0, coord_t'(16'sh7fff));
    send_item(ACT_UNUSED,  1'b0, 16'sd5, 16'sd5);
    // small triangle in pixel units; points inside, outside, on an edge
    send_item(ACT_LOAD,    1'b1, 16'sd0, 16'sd0);
    send_item(ACT_LOAD,    1'b0, 16'sd160, 16'sd0);
    send_item(ACT_LOAD,    1'b0, 16'sd0, 16'sd160);
    send_item(ACT_TEST,    1'b0, 16'sd16, 16'sd16);
    send_item(ACT_TEST,    1'b0, 16'sd160, 16'sd160);
    send_item(ACT_TEST,    1'b0, 16'sd0, 16'sd80);
    send_item(ACT_MEASURE, 1'b0, 16'sd0, 16'sd0);
    // append without restart: fourth vertex far down, box reaches the minimum
    send_item(ACT_LOAD,    1'b0, 16'sd80, coord_t'(16'sh8000));
    send_item(ACT_MEASURE, 1'b0, 16'sd0, 16'sd0);
    send_item(ACT_TEST,    1'b0, 16'sd80, -16'sd16);

    // --- random ---
    while (items_sent < TARGET_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 70)      run_polygon();
      else if (pick < 85) run_noise();
      else                run_short_polygon();
    end
    in_ch.valid <= 1'b0;

    // drain, then give the block time to show anything stray
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.fails == 0 && tracker.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hard stop in case the handshake hangs
  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
